// ===== hw/rtl/mck_pkg.sv =====
`default_nettype none

package mck_pkg;

  localparam int TABLE_ENTRIES = 36;
  localparam int CFG_IDX_W = 2;
  localparam int TIME_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DOT_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP_TIME = 2'd2;

  localparam logic [TIME_W-1:0] DOT_TIME_RST = 16'd200;
  localparam logic [TIME_W-1:0] DASH_TIME_RST = 16'd600;
  localparam logic [TIME_W-1:0] WORD_GAP_TIME_RST = 16'd1400;

  localparam logic [1:0] KIND_MARK = 2'd0;
  localparam logic [1:0] KIND_DARK = 2'd1;
  localparam logic [1:0] KIND_RED = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_flag;
  } in_t;

  typedef struct packed {
    logic [1:0]        element_kind;
    logic [TIME_W-1:0] duration;
    logic              last;
  } out_t;

  // One code: number of marks and dash mask, bit 0 is the first mark.
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] dash;
  } code_t;

  localparam code_t CODE_TABLE [TABLE_ENTRIES] = '{
    '{3'd2, 5'b00010}, '{3'd4, 5'b00001}, '{3'd4, 5'b00101}, '{3'd3, 5'b00001},
    '{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b00011}, '{3'd4, 5'b00000},
    '{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b00101}, '{3'd4, 5'b00010},
    '{3'd2, 5'b00011}, '{3'd2, 5'b00001}, '{3'd3, 5'b00111}, '{3'd4, 5'b00110},
    '{3'd4, 5'b01011}, '{3'd3, 5'b00010}, '{3'd3, 5'b00000}, '{3'd1, 5'b00001},
    '{3'd3, 5'b00100}, '{3'd4, 5'b01000}, '{3'd3, 5'b00110}, '{3'd4, 5'b01001},
    '{3'd4, 5'b01101}, '{3'd4, 5'b00011},
    '{3'd5, 5'b11111}, '{3'd5, 5'b11110}, '{3'd5, 5'b11100}, '{3'd5, 5'b11000},
    '{3'd5, 5'b10000}, '{3'd5, 5'b00000}, '{3'd5, 5'b00001}, '{3'd5, 5'b00011},
    '{3'd5, 5'b00111}, '{3'd5, 5'b01111}
  };

  typedef enum logic [1:0] {
    MODE_LETTER,
    MODE_RED,
    MODE_END
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/morse_char_keyer.sv =====
`default_nettype none

// Morse keyer: one ASCII character in, a run of timed key elements out.
// Input channel in_valid/in_stall/in_item carries a character or an
// end-of-message mark; an item is taken at an edge with in_valid high and
// in_stall low. Output channel out_valid/out_stall/out_item carries one
// element (kind, duration, last) per item; last flags the final element
// of each input item. Characters that encode to nothing give no output.
// Timing: a taken item is loaded into the sequencer, which then registers
// its elements into the output register one per cycle while the output
// register is free; an item produces up to 11 elements, and in_stall stays
// high until the last of them has been handed out and the sequencer is
// idle again. The element sequencer in the controller handles one item at a time.
// While out_stall is high, an element in the output register is held
// there and the sequencer waits; nothing is dropped.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data):
// index 0 dot time, 1 dash time, 2 red gap time; other indexes are ignored.
// Synchronous reset restores the default times (200, 600, 1400), clears
// the red gap tail count and empties the output register.

module morse_char_keyer
  import mck_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_item
);

  cmd_t    cmd;
  status_t status;

  mck_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mck_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mck_ctrl.sv =====
`default_nettype none

module mck_ctrl
  import mck_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_RUN;
      end
      ST_RUN: begin
        // leave once every element of the item has been handed out
        if (!status.more) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.emit = status.more && status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mck_dp.sv =====
`default_nettype none

module mck_dp
  import mck_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data,
  input  wire in_t                  in_item,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_item
);

  logic [TIME_W-1:0] dot_time;
  logic [TIME_W-1:0] dash_time;
  logic [TIME_W-1:0] word_gap_time;
  logic [1:0]        trailing_gaps;
  logic [1:0]        trailing_gaps_next;

  mode_t      mode;
  mode_t      mode_next;
  code_t      code;
  logic [3:0] total;
  logic [3:0] total_next;
  logic [3:0] step;

  logic [7:0] folded;
  logic [5:0] idx;
  logic [3:0] step_inc;
  logic [1:0] kind;
  logic [TIME_W-1:0] dur;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_time <= DOT_TIME_RST;
      dash_time <= DASH_TIME_RST;
      word_gap_time <= WORD_GAP_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DOT_TIME:      dot_time <= cfg_data;
        CFG_DASH_TIME:     dash_time <= cfg_data;
        CFG_WORD_GAP_TIME: word_gap_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify the incoming character
  always_comb begin
    folded = in_item.char_code;
    if (folded inside {[8'h61:8'h7a]}) folded = folded - 8'd32;
    idx = '0;
    mode_next = MODE_RED;
    total_next = '0;
    if (in_item.end_flag) begin
      mode_next = MODE_END;
      total_next = (trailing_gaps < 2'd2) ? 4'd1 : 4'd0;
    end else if (folded inside {[8'h41:8'h5a]}) begin
      mode_next = MODE_LETTER;
      idx = 6'(folded - 8'h41);
    end else if (folded inside {[8'h30:8'h39]}) begin
      mode_next = MODE_LETTER;
      idx = 6'(folded - 8'h30) + 6'd26;
    end else if (folded == 8'h20) begin
      total_next = 4'd1;
    end else if (folded inside {8'h2e, 8'h3f, 8'h21}) begin
      total_next = 4'd2;
    end
    if (mode_next == MODE_LETTER) total_next = {CODE_TABLE[idx].len, 1'b1};
  end

  // letters: marks and dark gaps alternate, red gap closes; else only red gaps
  always_comb begin
    kind = KIND_RED;
    dur = word_gap_time;
    if (mode == MODE_LETTER && step < {code.len, 1'b0}) begin
      if (step[0]) begin
        kind = KIND_DARK;
        dur = dot_time;
      end else begin
        kind = KIND_MARK;
        dur = code.dash[step[3:1]] ? dash_time : dot_time;
      end
    end
  end

  assign step_inc = step + 4'd1;

  always_comb begin
    trailing_gaps_next = trailing_gaps;
    if (cmd.load && in_item.end_flag) begin
      trailing_gaps_next = '0;
    end else if (cmd.emit && mode != MODE_END) begin
      if (kind == KIND_MARK) trailing_gaps_next = '0;
      else if (kind == KIND_RED && trailing_gaps < 2'd2)
        trailing_gaps_next = trailing_gaps + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trailing_gaps <= '0;
      step <= '0;
      total <= '0;
      mode <= MODE_RED;
      out_valid <= 1'b0;
    end else begin
      trailing_gaps <= trailing_gaps_next;
      if (cmd.load) begin
        step <= '0;
        total <= total_next;
        mode <= mode_next;
      end else if (cmd.emit) begin
        step <= step_inc;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) code <= CODE_TABLE[idx];
    if (cmd.emit) begin
      out_item.element_kind <= kind;
      out_item.duration <= dur;
      out_item.last <= (step_inc == total);
    end
  end

  assign status.more = step < total;
  assign status.out_free = !out_valid || !out_stall;

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> step < total)
    else $error("element emitted past the end of the item");

  a_no_load_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.emit))
    else $error("load and emit in the same cycle");

  a_mark_clears_tail: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && kind == KIND_MARK |=> trailing_gaps == 2'd0)
    else $error("mark did not clear the red gap tail");

  a_tail_saturates: assert property (@(posedge clk) disable iff (rst)
    trailing_gaps != 2'd3)
    else $error("red gap tail count overflowed");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted element not presented");

endmodule

`default_nettype wire

// ===== tb/morse_char_keyer_test.sv =====
`timescale 1ns / 100ps

module morse_char_keyer_test
  import mck_pkg::*;
;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 24;
  localparam int ITEMS_PER_PHASE = 65;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Directed expectations, all at the reset timing values
  localparam out_t NO_ELEM = '0;
  localparam out_t RED_MID = '{KIND_RED, WORD_GAP_TIME_RST, 1'b0};
  localparam out_t RED_END = '{KIND_RED, WORD_GAP_TIME_RST, 1'b1};
  localparam out_t DOT_MARK = '{KIND_MARK, DOT_TIME_RST, 1'b0};
  localparam out_t DASH_MARK = '{KIND_MARK, DASH_TIME_RST, 1'b0};
  localparam out_t DARK_GAP = '{KIND_DARK, DOT_TIME_RST, 1'b0};

  typedef struct packed {
    in_t          item;
    logic         typed;
    logic [1:0]   n;
    out_t [0:2]   exp;
  } row_t;

  localparam int DIR_ROWS = 25;
  localparam row_t DIRECTED [DIR_ROWS] = '{
    '{'{8'h00, 1'b1}, 1'b1, 2'd1, '{RED_END, NO_ELEM, NO_ELEM}},
    '{'{8'hFF, 1'b1}, 1'b1, 2'd1, '{RED_END, NO_ELEM, NO_ELEM}},
    '{'{8'h45, 1'b0}, 1'b1, 2'd3, '{DOT_MARK, DARK_GAP, RED_END}},
    '{'{8'h74, 1'b0}, 1'b1, 2'd3, '{DASH_MARK, DARK_GAP, RED_END}},
    '{'{8'h2E, 1'b0}, 1'b1, 2'd2, '{RED_MID, RED_END, NO_ELEM}},
    '{'{8'h00, 1'b1}, 1'b1, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h41, 1'b1}, 1'b1, 2'd1, '{RED_END, NO_ELEM, NO_ELEM}},
    '{'{8'h00, 1'b0}, 1'b1, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'hFF, 1'b0}, 1'b1, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h80, 1'b0}, 1'b1, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h30, 1'b0}, 1'b0, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h39, 1'b0}, 1'b0, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h41, 1'b0}, 1'b0, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h7A, 1'b0}, 1'b0, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h5A, 1'b0}, 1'b0, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h3F, 1'b0}, 1'b1, 2'd2, '{RED_MID, RED_END, NO_ELEM}},
    '{'{8'h21, 1'b0}, 1'b1, 2'd2, '{RED_MID, RED_END, NO_ELEM}},
    '{'{8'h20, 1'b0}, 1'b1, 2'd1, '{RED_END, NO_ELEM, NO_ELEM}},
    '{'{8'h55, 1'b1}, 1'b1, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h20, 1'b0}, 1'b1, 2'd1, '{RED_END, NO_ELEM, NO_ELEM}},
    '{'{8'h00, 1'b1}, 1'b1, 2'd1, '{RED_END, NO_ELEM, NO_ELEM}},
    '{'{8'h40, 1'b0}, 1'b1, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h7B, 1'b0}, 1'b1, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h2F, 1'b0}, 1'b1, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}},
    '{'{8'h3A, 1'b0}, 1'b1, 2'd0, '{NO_ELEM, NO_ELEM, NO_ELEM}}
  };

  // Letters A-Z, then digits 0-9
  string morse_codes [36] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
    ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
    "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-", ".....", "-....",
    "--...", "---..", "----."
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_item;

  row_t cur_row = '0;

  // Predictor state
  logic [TIME_W-1:0] dot_ms = DOT_TIME_RST;
  logic [TIME_W-1:0] dash_ms = DASH_TIME_RST;
  logic [TIME_W-1:0] red_ms = WORD_GAP_TIME_RST;
  logic [1:0]        red_tail = '0;
  out_t              char_elems [$];
  out_t              expected_elems [$];

  int failures = 0;
  int elems_checked = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_max = 3;
  int stall_mode = 0;
  int stall_span = 0;

  morse_char_keyer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void put_elem(logic [1:0] kind, logic [TIME_W-1:0] dur);
    out_t e;
    e.element_kind = kind;
    e.duration = dur;
    e.last = 1'b0;
    char_elems.push_back(e);
  endfunction

  function automatic void put_red();
    if (red_tail < 2'd2) red_tail = red_tail + 2'd1;
    put_elem(KIND_RED, red_ms);
  endfunction

  // Fill char_elems with the key elements that one item produces
  function automatic void encode_char(in_t it);
    logic [7:0] c;
    int idx;
    string code;
    char_elems.delete();
    c = it.char_code;
    idx = -1;
    if (it.end_flag) begin
      if (red_tail < 2'd2) put_red();
      red_tail = '0;
    end else begin
      if (c >= "a" && c <= "z") c = c - 8'd32;
      if (c >= "A" && c <= "Z") idx = int'(c - "A");
      else if (c >= "0" && c <= "9") idx = 26 + int'(c - "0");
      if (c == " ") begin
        put_red();
      end else if (c == "." || c == "?" || c == "!") begin
        put_red();
        put_red();
      end else if (idx >= 0) begin
        code = morse_codes[idx];
        for (int i = 0; i < code.len(); i++) begin
          put_elem(KIND_MARK, (code[i] == "-") ? dash_ms : dot_ms);
          put_elem(KIND_DARK, dot_ms);
        end
        red_tail = '0;
        put_red();
      end
    end
    if (char_elems.size() > 0) char_elems[char_elems.size() - 1].last = 1'b1;
  endfunction

  // Register writes, result checks and item capture, all sampled at the edge
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      dot_ms = DOT_TIME_RST;
      dash_ms = DASH_TIME_RST;
      red_ms = WORD_GAP_TIME_RST;
      red_tail = '0;
      expected_elems.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DOT_TIME: dot_ms = cfg_data;
          CFG_DASH_TIME: dash_ms = cfg_data;
          CFG_WORD_GAP_TIME: red_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_elems.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected element: kind %0d dur %0d last %0d",
                     out_item.element_kind, out_item.duration, out_item.last);
        end else begin
          want = expected_elems.pop_front();
          if (out_item.element_kind !== want.element_kind ||
              out_item.duration !== want.duration || out_item.last !== want.last) begin
            failures++;
            if (failures <= 10)
              $display("element %0d: expected kind %0d dur %0d last %0d, got kind %0d dur %0d last %0d",
                       elems_checked, want.element_kind, want.duration, want.last,
                       out_item.element_kind, out_item.duration, out_item.last);
          end
        end
        elems_checked++;
      end
      if (in_valid && !in_stall) begin
        encode_char(in_item);
        if (cur_row.typed) begin
          for (int i = 0; i < cur_row.n; i++) expected_elems.push_back(cur_row.exp[i]);
        end else begin
          foreach (char_elems[i]) expected_elems.push_back(char_elems[i]);
        end
      end
    end
  end

  // Receiver: spans of no stall, random stall and long stall runs
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= (stall_span % 16) < 10;
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d elements outstanding",
               cycle_count, expected_elems.size());
      $display("** morse_char_keyer: FAILED **");
      $finish;
    end
  end

  // Present one item, hold it until taken, then either keep the burst going or idle
  task automatic send_item(input row_t r);
    in_valid <= 1'b1;
    in_item <= r.item;
    cur_row <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
      gap_max = ($urandom_range(0, 4) == 0) ? 20 : 4;
    end
  endtask

  task automatic send_plain(input logic [7:0] c, input logic e);
    row_t r;
    r = '0;
    r.item.char_code = c;
    r.item.end_flag = e;
    send_item(r);
  endtask

  // Mostly message text; some raw bytes as noise
  task automatic send_random_char(inout int counted);
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "a" : "A");
      4: c = 8'($urandom_range(0, 9)) + "0";
      5: c = " ";
      6: begin
        case ($urandom_range(0, 2))
          0: c = ".";
          1: c = "?";
          default: c = "!";
        endcase
      end
      7: c = 8'($urandom_range(0, 255));
      default: c = 8'($urandom_range(0, 25)) + "A";
    endcase
    send_plain(c, 1'b0);
    counted++;
  endtask

  // Drop valid and wait until every element is out and the sequencer is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_times(input logic [TIME_W-1:0] dot_v, dash_v, gap_v);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [TIME_W-1:0] val [4];
    idx = '{CFG_DOT_TIME, CFG_DASH_TIME, CFG_WORD_GAP_TIME, CFG_UNUSED};
    val = '{dot_v, dash_v, gap_v, TIME_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int counted;
    int msg_len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) send_item(DIRECTED[i]);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: program_times(16'd1, 16'd1, 16'd1);
        1: program_times(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: program_times(16'd0, 16'd0, 16'd0);
        3: program_times(16'd100, 16'd300, 16'd700);
        default: program_times(TIME_W'($urandom_range(1, 65535)),
                               TIME_W'($urandom_range(1, 65535)),
                               TIME_W'($urandom_range(1, 65535)));
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        msg_len = $urandom_range(0, 8);
        for (int k = 0; k < msg_len; k++) send_random_char(counted);
        // most messages are closed; some run on, some get a double end
        if ($urandom_range(0, 4) != 0) begin
          send_plain(8'($urandom_range(0, 255)), 1'b1);
          counted++;
          if ($urandom_range(0, 5) == 0) begin
            send_plain(8'($urandom_range(0, 255)), 1'b1);
            counted++;
          end
        end
      end
    end
    settle();

    if (expected_elems.size() != 0) begin
      failures += expected_elems.size();
      $display("%0d expected elements never arrived", expected_elems.size());
    end
    $display("Sent %0d items (%0d directed) over 7 timing settings incl. minimum,",
             items_sent, DIR_ROWS);
    $display("all-ones and zero; %0d key elements checked, %0d failures.",
             elems_checked, failures);
    if (failures == 0) begin
      $display("** morse_char_keyer: PASSED **");
    end else begin
      $display("** morse_char_keyer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mck_pkg.sv
hw/rtl/mck_ctrl.sv
hw/rtl/mck_dp.sv
hw/rtl/morse_char_keyer.sv
tb/morse_char_keyer_test.sv
